### design/rat_alu_pkg.sv
// Package for the rational accumulator ALU.
// Holds the operation, status and shared-unit mode codes; no dependencies.
`timescale 1ns / 1ps
package rat_alu_pkg;

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // shared unit modes
  localparam logic [1:0] UM_MUL = 2'd0;
  localparam logic [1:0] UM_DIV = 2'd1;
  localparam logic [1:0] UM_GCD = 2'd2;

endpackage

### design/rational_accumulator_alu.sv
// Rational accumulator ALU: sequencer plus one shared add/subtract unit that runs
// shift-add multiply, restoring divide and binary gcd. Uses rat_alu_pkg.
`timescale 1ns / 1ps
// Load reduces by a gcd and two divides; multiply and divide run two multiplies, add and
// subtract a gcd, three divides and three multiplies, then the result is reduced; every gcd,
// multiply and divide runs on the one shared adder/subtractor.
// One request at a time: in_ready is high only while the block is idle.
// Reset (synchronous, rst_n low) sets the accumulator to 0/1 and drops any request.
module rational_accumulator_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_operation,
  input  logic signed [DATA_WIDTH-1:0] in_operand_numerator,
  input  logic signed [DATA_WIDTH-1:0] in_operand_denominator,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_result_numerator,
  output logic signed [DATA_WIDTH-1:0] out_result_denominator,
  output logic [1:0]                   out_status
);
  import rat_alu_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_AGCD  = 5'd2;
  localparam logic [4:0] S_ADIV1 = 5'd3;
  localparam logic [4:0] S_AMUL1 = 5'd4;
  localparam logic [4:0] S_ADIV2 = 5'd5;
  localparam logic [4:0] S_AMUL2 = 5'd6;
  localparam logic [4:0] S_ADIV3 = 5'd7;
  localparam logic [4:0] S_AMUL3 = 5'd8;
  localparam logic [4:0] S_AADD  = 5'd9;
  localparam logic [4:0] S_MN    = 5'd10;
  localparam logic [4:0] S_MD    = 5'd11;
  localparam logic [4:0] S_RED   = 5'd12;
  localparam logic [4:0] S_RGCD  = 5'd13;
  localparam logic [4:0] S_RDN   = 5'd14;
  localparam logic [4:0] S_RDD   = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic is_min(input logic [W-1:0] x);
    is_min = x[W-1] && (x[W-2:0] == '0);
  endfunction

  logic [4:0]   state_r;
  logic         wait_r;
  logic [2:0]   op_r;
  logic [1:0]   st_r;
  logic [W-1:0] acc_n_r, acc_d_r, bn_r, bd_r, n_r, d_r, l_r, tmp_r, t1_r;

  // shared unit
  logic         u_busy_r, u_done_r;
  logic [1:0]   u_mode_r;
  logic [W:0]   u_hi_r;
  logic [W-1:0] u_lo_r, u_mc_r;
  logic [CW-1:0] u_cnt_r, u_k_r;
  logic         u_start;
  logic [1:0]   u_sel;
  logic [W-1:0] u_opa, u_opb;
  logic [W:0]   alu_a, alu_b, alu_res, mul_nh;
  logic         alu_sub;

  logic         mul_neg, mul_ovf;
  logic [W-1:0] mul_res, quo_n, quo_d;
  logic [W:0]   sum_e;
  logic         sum_ovf;
  logic [W-1:0] x_mul, y_mul;

  always_comb begin
    case (u_mode_r)
      UM_MUL: begin
        alu_a   = u_hi_r;
        alu_sub = 1'b0;
      end
      UM_DIV: begin
        alu_a   = {u_hi_r[W-1:0], u_lo_r[W-1]};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = {1'b0, u_lo_r};
        alu_sub = 1'b1;
      end
    endcase
    alu_b   = {1'b0, u_mc_r};
    alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    mul_nh  = u_lo_r[0] ? alu_res : u_hi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_busy_r <= 1'b0;
      u_done_r <= 1'b0;
    end else begin
      u_done_r <= 1'b0;
      if (u_start) begin
        u_busy_r <= 1'b1;
        u_mode_r <= u_sel;
        u_hi_r   <= '0;
        u_lo_r   <= u_opa;
        u_mc_r   <= u_opb;
        u_cnt_r  <= '0;
        u_k_r    <= '0;
      end else if (u_busy_r) begin
        case (u_mode_r)
          UM_MUL: begin
            u_hi_r  <= {1'b0, mul_nh[W:1]};
            u_lo_r  <= {mul_nh[0], u_lo_r[W-1:1]};
            u_cnt_r <= u_cnt_r + 1'b1;
            if (u_cnt_r == CW'(W - 1)) begin
              u_busy_r <= 1'b0;
              u_done_r <= 1'b1;
            end
          end
          UM_DIV: begin
            u_hi_r  <= alu_res[W] ? alu_a : alu_res;
            u_lo_r  <= {u_lo_r[W-2:0], ~alu_res[W]};
            u_cnt_r <= u_cnt_r + 1'b1;
            if (u_cnt_r == CW'(W - 1)) begin
              u_busy_r <= 1'b0;
              u_done_r <= 1'b1;
            end
          end
          default: begin
            // binary gcd: strip common twos, drop lone twos, subtract or swap
            if (u_lo_r == '0) begin
              u_lo_r   <= u_mc_r << u_k_r;
              u_busy_r <= 1'b0;
              u_done_r <= 1'b1;
            end else if (!u_lo_r[0] && !u_mc_r[0]) begin
              u_lo_r <= u_lo_r >> 1;
              u_mc_r <= u_mc_r >> 1;
              u_k_r  <= u_k_r + 1'b1;
            end else if (!u_lo_r[0]) begin
              u_lo_r <= u_lo_r >> 1;
            end else if (!u_mc_r[0]) begin
              u_mc_r <= u_mc_r >> 1;
            end else if (alu_res[W]) begin
              u_lo_r <= u_mc_r;
              u_mc_r <= u_lo_r;
            end else begin
              u_lo_r <= alu_res[W-1:0];
            end
          end
        endcase
      end
    end
  end

  // operand selection per step
  always_comb begin
    x_mul   = (state_r == S_MN) ? acc_n_r : acc_d_r;
    if (state_r == S_MN) y_mul = (op_r == OP_MUL) ? bn_r : bd_r;
    else                 y_mul = (op_r == OP_MUL) ? bd_r : bn_r;
    u_sel   = UM_MUL;
    u_opa   = '0;
    u_opb   = '0;
    mul_neg = 1'b0;
    case (state_r)
      S_AGCD: begin
        u_sel = UM_GCD; u_opa = mag(acc_d_r); u_opb = mag(bd_r);
      end
      S_ADIV1: begin
        u_sel = UM_DIV; u_opa = mag(acc_d_r); u_opb = tmp_r;
      end
      S_AMUL1: begin
        u_opa = tmp_r; u_opb = mag(bd_r);
      end
      S_ADIV2: begin
        u_sel = UM_DIV; u_opa = l_r; u_opb = mag(acc_d_r);
      end
      S_AMUL2: begin
        u_opa = mag(acc_n_r); u_opb = tmp_r; mul_neg = acc_n_r[W-1] ^ acc_d_r[W-1];
      end
      S_ADIV3: begin
        u_sel = UM_DIV; u_opa = l_r; u_opb = mag(bd_r);
      end
      S_AMUL3: begin
        u_opa = mag(bn_r); u_opb = tmp_r; mul_neg = bn_r[W-1] ^ bd_r[W-1];
      end
      S_MN, S_MD: begin
        u_opa = mag(x_mul); u_opb = mag(y_mul); mul_neg = x_mul[W-1] ^ y_mul[W-1];
      end
      S_RGCD: begin
        u_sel = UM_GCD; u_opa = mag(n_r); u_opb = mag(d_r);
      end
      S_RDN: begin
        u_sel = UM_DIV; u_opa = mag(n_r); u_opb = tmp_r;
      end
      S_RDD: begin
        u_sel = UM_DIV; u_opa = mag(d_r); u_opb = tmp_r;
      end
      default: begin
        u_sel = UM_MUL;
      end
    endcase
    u_start = !wait_r && (state_r != S_IDLE) && (state_r != S_DISP) &&
              (state_r != S_AADD) && (state_r != S_RED) && (state_r != S_OUT);
  end

  always_comb begin
    mul_ovf = (u_hi_r[W-1:0] != '0) ||
              (u_lo_r[W-1] && !(mul_neg && (u_lo_r[W-2:0] == '0)));
    mul_res = mul_neg ? (~u_lo_r + 1'b1) : u_lo_r;
    quo_n   = n_r[W-1] ? (~u_lo_r + 1'b1) : u_lo_r;
    quo_d   = d_r[W-1] ? (~u_lo_r + 1'b1) : u_lo_r;
    sum_e   = (op_r == OP_SUB) ? ({t1_r[W-1], t1_r} - {n_r[W-1], n_r})
                               : ({t1_r[W-1], t1_r} + {n_r[W-1], n_r});
    sum_ovf = sum_e[W] ^ sum_e[W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wait_r  <= 1'b0;
      acc_n_r <= '0;
      acc_d_r <= {{(W-1){1'b0}}, 1'b1};
      st_r    <= ST_OK;
    end else begin
      if (u_start) wait_r <= 1'b1;
      if (u_done_r) wait_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_operation;
            bn_r    <= in_operand_numerator;
            bd_r    <= in_operand_denominator;
            st_r    <= ST_OK;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          case (op_r)
            OP_LOAD: begin
              n_r <= bn_r;
              d_r <= bd_r;
              if (bd_r == '0) begin
                st_r <= ST_ZERO_DEN; state_r <= S_OUT;
              end else begin
                state_r <= S_RED;
              end
            end
            OP_ADD, OP_SUB: begin
              if (acc_d_r == '0 || bd_r == '0) begin
                st_r <= ST_ZERO_DEN; state_r <= S_OUT;
              end else if (is_min(acc_d_r) || is_min(bd_r)) begin
                st_r <= ST_OVERFLOW; state_r <= S_OUT;
              end else begin
                state_r <= S_AGCD;
              end
            end
            OP_MUL, OP_DIV: begin
              if (acc_d_r == '0 || (op_r == OP_MUL ? bd_r : bn_r) == '0) begin
                st_r <= ST_ZERO_DEN; state_r <= S_OUT;
              end else begin
                state_r <= S_MN;
              end
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_AGCD: if (u_done_r) begin tmp_r <= u_lo_r; state_r <= S_ADIV1; end
        S_ADIV1: if (u_done_r) begin tmp_r <= u_lo_r; state_r <= S_AMUL1; end
        S_AMUL1: if (u_done_r) begin
          l_r <= u_lo_r;
          if (mul_ovf) begin st_r <= ST_OVERFLOW; state_r <= S_OUT; end
          else state_r <= S_ADIV2;
        end
        S_ADIV2: if (u_done_r) begin tmp_r <= u_lo_r; state_r <= S_AMUL2; end
        S_AMUL2: if (u_done_r) begin
          t1_r <= mul_res;
          if (mul_ovf) begin st_r <= ST_OVERFLOW; state_r <= S_OUT; end
          else state_r <= S_ADIV3;
        end
        S_ADIV3: if (u_done_r) begin tmp_r <= u_lo_r; state_r <= S_AMUL3; end
        S_AMUL3: if (u_done_r) begin
          n_r <= mul_res;
          if (mul_ovf) begin st_r <= ST_OVERFLOW; state_r <= S_OUT; end
          else state_r <= S_AADD;
        end
        S_AADD: begin
          n_r <= sum_e[W-1:0];
          d_r <= l_r;
          if (sum_ovf) begin st_r <= ST_OVERFLOW; state_r <= S_OUT; end
          else state_r <= S_RED;
        end
        S_MN: if (u_done_r) begin
          n_r <= mul_res;
          if (mul_ovf) begin st_r <= ST_OVERFLOW; state_r <= S_OUT; end
          else state_r <= S_MD;
        end
        S_MD: if (u_done_r) begin
          d_r <= mul_res;
          if (mul_ovf) begin st_r <= ST_OVERFLOW; state_r <= S_OUT; end
          else state_r <= S_RED;
        end
        S_RED: begin
          if (is_min(n_r) || is_min(d_r)) begin
            st_r <= ST_OVERFLOW; state_r <= S_OUT;
          end else if (n_r == '0 || d_r == '0) begin
            // gcd with a zero argument counts as one
            acc_n_r <= n_r; acc_d_r <= d_r; state_r <= S_OUT;
          end else begin
            state_r <= S_RGCD;
          end
        end
        S_RGCD: if (u_done_r) begin tmp_r <= u_lo_r; state_r <= S_RDN; end
        S_RDN: if (u_done_r) begin n_r <= quo_n; state_r <= S_RDD; end
        S_RDD: if (u_done_r) begin
          acc_n_r <= n_r; acc_d_r <= quo_d; state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready               = (state_r == S_IDLE);
  assign out_valid              = (state_r == S_OUT);
  assign out_result_numerator   = acc_n_r;
  assign out_result_denominator = acc_d_r;
  assign out_status             = st_r;

endmodule
